// ----- hw/rtl/lkd_pkg.sv -----
`default_nettype none

package lkd_pkg;

    // Field widths fixed by the interface
    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned SHORT_CFG_W = 16;
    localparam int unsigned LONG_CFG_W  = 22;
    localparam int unsigned CFG_DATA_W  = 22;
    localparam int unsigned CFG_IDX_W   = 2;

    // Default timer widths
    localparam int unsigned SHORT_TIMER_BITS_DEF = 16;
    localparam int unsigned LONG_TIMER_BITS_DEF  = 22;

    // Ladder thresholds (exclusive upper bounds)
    localparam logic [SAMPLE_W-1:0] THR_LEFT   = 10'd70;
    localparam logic [SAMPLE_W-1:0] THR_UP     = 10'd230;
    localparam logic [SAMPLE_W-1:0] THR_DOWN   = 10'd420;
    localparam logic [SAMPLE_W-1:0] THR_RIGHT  = 10'd620;
    localparam logic [SAMPLE_W-1:0] THR_SELECT = 10'd900;

    // Register reset values
    localparam logic [SHORT_CFG_W-1:0] DEBOUNCE_RST = 16'd80;
    localparam logic [SHORT_CFG_W-1:0] REPEAT_RST   = 16'd350;
    localparam logic [LONG_CFG_W-1:0]  DIM_RST      = 22'd5000;
    localparam logic [LONG_CFG_W-1:0]  SLEEP_RST    = 22'd10000;

    typedef enum logic [2:0] {
        KEY_NONE   = 3'd0,
        KEY_RIGHT  = 3'd1,
        KEY_UP     = 3'd2,
        KEY_DOWN   = 3'd3,
        KEY_LEFT   = 3'd4,
        KEY_SELECT = 3'd5
    } key_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_FULL  = 2'd1,
        ACT_DIM   = 2'd2,
        ACT_SLEEP = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_REPEAT   = 2'd1,
        REG_DIM      = 2'd2,
        REG_SLEEP    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SHORT_CFG_W-1:0] debounce_ticks;
        logic [SHORT_CFG_W-1:0] repeat_ticks;
        logic [LONG_CFG_W-1:0]  dim_after_ticks;
        logic [LONG_CFG_W-1:0]  sleep_after_ticks;
    } lkd_cfg_t;

    typedef struct packed {
        logic    key_valid;
        key_t    key_code;
        logic    is_repeat;
        action_t backlight_action;
        logic    display_awake;
        logic    display_dimmed;
    } lkd_result_t;

    // Ladder voltage to key
    function automatic key_t decode_ladder(input logic [SAMPLE_W-1:0] s);
        key_t k;
        if (s < THR_LEFT) begin
            k = KEY_LEFT;
        end else if (s < THR_UP) begin
            k = KEY_UP;
        end else if (s < THR_DOWN) begin
            k = KEY_DOWN;
        end else if (s < THR_RIGHT) begin
            k = KEY_RIGHT;
        end else if (s < THR_SELECT) begin
            k = KEY_SELECT;
        end else begin
            k = KEY_NONE;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ladder_keypad_debounce_repeat_idle.sv -----
// Ladder keypad front end: decode, debounce, auto-repeat, display idle control.
// Result is registered: valid on the m_ channel in the cycle after item acceptance.
// Throughput: one item per cycle while the result register is empty or draining.
// Reset (aresetn low, synchronous): timer registers take defaults 80/350/5000/10000,
// all key and idle state clears, display flags clear, result register empty.
`default_nettype none

module ladder_keypad_debounce_repeat_idle #(
    parameter int unsigned SHORT_TIMER_BITS = lkd_pkg::SHORT_TIMER_BITS_DEF,
    parameter int unsigned LONG_TIMER_BITS  = lkd_pkg::LONG_TIMER_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [lkd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lkd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // sample items
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [lkd_pkg::SAMPLE_W-1:0]    s_adc_sample,
    // result items
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_key_valid,
    output logic [2:0]                           m_key_code,
    output logic                                 m_is_repeat,
    output logic [1:0]                           m_backlight_action,
    output logic                                 m_display_awake,
    output logic                                 m_display_dimmed
);
    import lkd_pkg::*;

    lkd_cfg_t    cfg_reg;
    lkd_result_t step_res;
    lkd_result_t res_reg;
    logic        m_valid_reg;
    logic        accept;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks    <= DEBOUNCE_RST;
            cfg_reg.repeat_ticks      <= REPEAT_RST;
            cfg_reg.dim_after_ticks   <= DIM_RST;
            cfg_reg.sleep_after_ticks <= SLEEP_RST;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_DEBOUNCE: cfg_reg.debounce_ticks    <= cfg_wr_data[SHORT_CFG_W-1:0];
                REG_REPEAT:   cfg_reg.repeat_ticks      <= cfg_wr_data[SHORT_CFG_W-1:0];
                REG_DIM:      cfg_reg.dim_after_ticks   <= cfg_wr_data[LONG_CFG_W-1:0];
                REG_SLEEP:    cfg_reg.sleep_after_ticks <= cfg_wr_data[LONG_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Take an item whenever the result register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    lkd_core #(
        .SHORT_TIMER_BITS (SHORT_TIMER_BITS),
        .LONG_TIMER_BITS  (LONG_TIMER_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step_en (accept),
        .sample  (s_adc_sample),
        .result  (step_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= step_res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_key_valid        = res_reg.key_valid;
    assign m_key_code         = res_reg.key_code;
    assign m_is_repeat        = res_reg.is_repeat;
    assign m_backlight_action = res_reg.backlight_action;
    assign m_display_awake    = res_reg.display_awake;
    assign m_display_dimmed   = res_reg.display_dimmed;

`ifndef SYNTHESIS
    // an event always carries a backlight action
    a_event_has_action: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_key_valid) |-> (m_backlight_action != ACT_NONE))
        else $error("key event without backlight action");

    // no event means empty key fields
    a_idle_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_key_valid) |-> (m_key_code == KEY_NONE && !m_is_repeat))
        else $error("key fields set without event");

    // sleep leaves both flags clear
    a_sleep_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_backlight_action == ACT_SLEEP) |->
            (!m_display_awake && !m_display_dimmed))
        else $error("sleep with display flags set");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/lkd_core.sv -----
`default_nettype none

module lkd_core #(
    parameter int unsigned SHORT_TIMER_BITS = lkd_pkg::SHORT_TIMER_BITS_DEF,
    parameter int unsigned LONG_TIMER_BITS  = lkd_pkg::LONG_TIMER_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lkd_pkg::lkd_cfg_t             cfg,
    input  wire logic                          step_en,
    input  wire logic [lkd_pkg::SAMPLE_W-1:0]  sample,
    output lkd_pkg::lkd_result_t               result
);
    import lkd_pkg::*;

    // Compare widths cover both counter and register
    localparam int unsigned SW = (SHORT_TIMER_BITS > SHORT_CFG_W) ? SHORT_TIMER_BITS
                                                                  : SHORT_CFG_W;
    localparam int unsigned LW = (LONG_TIMER_BITS > LONG_CFG_W) ? LONG_TIMER_BITS
                                                                : LONG_CFG_W;

    key_t                        last_raw_reg, last_raw_next;
    key_t                        stable_reg, stable_next;
    key_t                        handled_reg, handled_next;
    logic [SHORT_TIMER_BITS-1:0] change_el_reg, change_el_next;
    logic [SHORT_TIMER_BITS-1:0] handled_el_reg, handled_el_next;
    logic [LONG_TIMER_BITS-1:0]  idle_el_reg, idle_el_next;
    logic                        awake_reg, awake_next;
    logic                        dimmed_reg, dimmed_next;

    key_t                        raw;
    logic [SHORT_TIMER_BITS-1:0] change_inc, handled_inc;
    logic [LONG_TIMER_BITS-1:0]  idle_inc;
    logic                        first_press, again;
    logic                        fire;
    action_t                     action;

    // Next state for one tick
    always_comb begin
        raw = decode_ladder(sample);

        // saturating counters
        change_inc  = (&change_el_reg)  ? change_el_reg  : change_el_reg + 1'b1;
        handled_inc = (&handled_el_reg) ? handled_el_reg : handled_el_reg + 1'b1;
        idle_inc    = (&idle_el_reg)    ? idle_el_reg    : idle_el_reg + 1'b1;

        // debounce
        if (raw != last_raw_reg) begin
            last_raw_next  = raw;
            change_el_next = '0;
        end else begin
            last_raw_next  = last_raw_reg;
            change_el_next = change_inc;
        end
        stable_next = (SW'(change_el_next) >= SW'(cfg.debounce_ticks)) ? raw : stable_reg;

        // press / repeat events
        first_press = (handled_reg == KEY_NONE);
        again = (stable_next != KEY_SELECT) && (stable_next == handled_reg) &&
                (SW'(handled_inc) >= SW'(cfg.repeat_ticks));
        fire  = (stable_next != KEY_NONE) && (first_press || again);

        handled_next    = handled_reg;
        handled_el_next = handled_inc;
        idle_el_next    = idle_inc;
        awake_next      = awake_reg;
        dimmed_next     = dimmed_reg;
        action          = ACT_NONE;
        if (stable_next == KEY_NONE) begin
            handled_next = KEY_NONE;
        end else if (fire) begin
            handled_next    = stable_next;
            handled_el_next = '0;
            idle_el_next    = '0;
            awake_next      = 1'b1;
            dimmed_next     = 1'b0;
            action          = ACT_FULL;
        end

        // idle power control, later action wins
        if (awake_next) begin
            if (LW'(idle_el_next) >= LW'(cfg.sleep_after_ticks)) begin
                awake_next  = 1'b0;
                dimmed_next = 1'b0;
                action      = ACT_SLEEP;
            end else if ((LW'(idle_el_next) >= LW'(cfg.dim_after_ticks)) && !dimmed_next) begin
                dimmed_next = 1'b1;
                action      = ACT_DIM;
            end
        end

        result.key_valid        = fire;
        result.key_code         = fire ? stable_next : KEY_NONE;
        result.is_repeat        = fire && !first_press;
        result.backlight_action = action;
        result.display_awake    = awake_next;
        result.display_dimmed   = dimmed_next;
    end

    // State advances once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg   <= KEY_NONE;
            stable_reg     <= KEY_NONE;
            handled_reg    <= KEY_NONE;
            change_el_reg  <= '0;
            handled_el_reg <= '0;
            idle_el_reg    <= '0;
            awake_reg      <= 1'b0;
            dimmed_reg     <= 1'b0;
        end else if (step_en) begin
            last_raw_reg   <= last_raw_next;
            stable_reg     <= stable_next;
            handled_reg    <= handled_next;
            change_el_reg  <= change_el_next;
            handled_el_reg <= handled_el_next;
            idle_el_reg    <= idle_el_next;
            awake_reg      <= awake_next;
            dimmed_reg     <= dimmed_next;
        end
    end

`ifndef SYNTHESIS
    // dimmed only ever set while awake
    a_dim_needs_awake: assert property (@(posedge aclk) disable iff (!aresetn)
        dimmed_reg |-> awake_reg)
        else $error("dimmed while asleep");

    // a repeat needs the same key already handled
    a_repeat_same_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.is_repeat) |-> (result.key_code == handled_reg))
        else $error("repeat of a key not held");

    // an event restarts the repeat timer
    a_event_clears_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.key_valid) |=> (handled_el_reg == '0))
        else $error("repeat timer not cleared by event");
`endif

endmodule

`default_nettype wire
